// ===== rtl/core/b2d_pkg.sv =====
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int VALUE_BITS = 16;
    localparam int MAX_DIGITS = 5;
    localparam int DIGIT_BITS = 4;
    localparam int COUNT_BITS = $clog2(MAX_DIGITS + 1);
    localparam int IDX_BITS   = $clog2(MAX_DIGITS);
    localparam int CHAR_BITS  = 6;

    // q = (v * 0xCCCD) >> 19 is exact for every 16-bit v
    localparam int                    RECIP_BITS  = 17;
    localparam logic [RECIP_BITS-1:0] RECIP_MULT  = 17'h0CCCD;
    localparam int                    RECIP_SHIFT = 19;
    localparam int                    PROD_BITS   = VALUE_BITS + RECIP_BITS;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;

    typedef logic [DIGIT_BITS-1:0] digit_t;

    // work carried down the digit pipeline
    typedef struct packed {
        logic [VALUE_BITS-1:0]                rem;
        logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] digits;
        logic [COUNT_BITS-1:0]                ndig;
    } work_t;

endpackage

// ===== rtl/core/b2d_if.sv =====
// ----------------------------------------------------------------------------
// b2d_if
// Valid/ready channels: number requests in, text characters out.
// ----------------------------------------------------------------------------
interface b2d_num_if;
    logic                           valid;
    logic                           ready;
    logic [b2d_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2d_text_if;
    logic                          valid;
    logic                          ready;
    logic [b2d_pkg::CHAR_BITS-1:0] character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/b2d_digit_stage.sv =====
// ----------------------------------------------------------------------------
// b2d_digit_stage
// One pipeline stage: splits off one decimal digit by reciprocal multiply.
// ----------------------------------------------------------------------------
module b2d_digit_stage #(
    parameter int STAGE = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  b2d_pkg::work_t up_work,
    output logic           dn_valid,
    input  logic           dn_ready,
    output b2d_pkg::work_t dn_work
);

    logic                           valid_reg;
    b2d_pkg::work_t                 work_reg;
    b2d_pkg::work_t                 work_next;
    logic [b2d_pkg::PROD_BITS-1:0]  product;
    logic [b2d_pkg::VALUE_BITS-1:0] quot;
    logic [b2d_pkg::VALUE_BITS-1:0] diff;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

    always_comb
    begin
        product = b2d_pkg::PROD_BITS'(up_work.rem) * b2d_pkg::PROD_BITS'(b2d_pkg::RECIP_MULT);
        quot    = b2d_pkg::VALUE_BITS'(product >> b2d_pkg::RECIP_SHIFT);
        // remainder: rem - 10*q, 10*q as two shifts
        diff    = up_work.rem - ((quot << 3) + (quot << 1));

        work_next                = up_work;
        work_next.rem            = quot;
        work_next.digits[STAGE]  = diff[b2d_pkg::DIGIT_BITS-1:0];
        if ((STAGE == 0) || (up_work.rem != '0))
        begin
            work_next.ndig = b2d_pkg::COUNT_BITS'(STAGE + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// ===== rtl/core/b2d_serialiser.sv =====
// ----------------------------------------------------------------------------
// b2d_serialiser
// Holds one converted number and sends its digits, most significant first.
// ----------------------------------------------------------------------------
module b2d_serialiser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  b2d_pkg::work_t up_work,
    b2d_text_if.source     text
);

    logic                                               busy_reg;
    logic [b2d_pkg::IDX_BITS-1:0]                       idx_reg;
    logic [b2d_pkg::MAX_DIGITS-1:0][b2d_pkg::DIGIT_BITS-1:0] digits_reg;
    logic                                               fire;
    logic                                               final_digit;
    b2d_pkg::digit_t                                    cur_digit;

    assign final_digit = (idx_reg == '0);
    assign fire        = busy_reg && text.ready;
    assign up_ready    = !busy_reg || (text.ready && final_digit);

    assign cur_digit      = digits_reg[idx_reg];
    assign text.valid     = busy_reg;
    assign text.character = b2d_pkg::CHAR_ZERO + b2d_pkg::CHAR_BITS'(cur_digit);
    assign text.last      = final_digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (up_ready && up_valid)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= b2d_pkg::IDX_BITS'(up_work.ndig - 1'b1);
        end
        else if (fire)
        begin
            if (final_digit)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            digits_reg <= up_work.digits;
        end
    end

endmodule

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 16-bit unsigned binary to decimal ASCII text, one character per request.
// ----------------------------------------------------------------------------
// Usage:
//   number : sink channel, one 16-bit unsigned value per request.
//   text   : source channel, one ASCII digit ('0'..'9') per request, most
//            significant first, no leading zeros; last marks the final digit.
//            Zero gives the single character '0' with last set.
// Path: the edge that accepts a number loads digit stage 0, the number is
//   carried on through digit stages 1 to 4 in turn, and then the output
//   register loads and shows its first character.
// Throughput: a new number enters every cycle while the pipe has room; the
//   sustained rate is set by the output register sending one character per
//   cycle while text.ready is high, one for each digit (1 to 5) of a number.
// Reset: rst_n clears all valid bits and the output; the data registers are not reset.
// Stall: while text.ready is low the character holds, the pipe fills up
//   stage by stage and number.ready drops once every stage is occupied;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
    input  logic       clk,
    input  logic       rst_n,
    b2d_num_if.sink    number,
    b2d_text_if.source text
);

    localparam int NSTAGE = b2d_pkg::MAX_DIGITS;

    // link k feeds digit stage k; the last link feeds the serialiser
    logic           link_valid [NSTAGE+1];
    logic           link_ready [NSTAGE+1];
    b2d_pkg::work_t link_work  [NSTAGE+1];

    always_comb
    begin
        link_work[0]      = '0;
        link_work[0].rem  = number.value;
    end

    assign link_valid[0] = number.valid;
    assign number.ready  = link_ready[0];

    // one digit, least significant first, per stage
    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_stage
        b2d_digit_stage #(
            .STAGE (k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_work  (link_work[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_work  (link_work[k+1])
        );
    end

    // output register: replays the digits in the opposite order
    b2d_serialiser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_valid[NSTAGE]),
        .up_ready (link_ready[NSTAGE]),
        .up_work  (link_work[NSTAGE]),
        .text     (text)
    );

endmodule

// ===== rtl/core/b2d_checker.sv =====
// ----------------------------------------------------------------------------
// b2d_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module b2d_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [b2d_pkg::CHAR_BITS-1:0] out_char,
    input logic                          out_last
);

    logic [3:0] pending_reg;
    logic       first_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // numbers accepted but not yet finished
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            first_reg   <= 1'b1;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(in_fire) - 4'(out_fire && out_last);
            if (out_fire)
            begin
                first_reg <= out_last;
            end
        end
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("character shown with no number outstanding");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_char >= b2d_pkg::CHAR_ZERO) &&
                       (out_char <= b2d_pkg::CHAR_ZERO + 6'd9)))
        else $error("character is not a decimal digit");

    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_reg && !out_last) |-> (out_char != b2d_pkg::CHAR_ZERO))
        else $error("leading zero emitted");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
        else $error("stalled character changed");

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.character),
    .out_last  (text.last)
);

// ===== sim/binary_to_decimal_ascii_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_test
// Drives numbers into the converter and checks every ASCII digit it sends
// back, with its last flag, against digits worked out here in order.
// ----------------------------------------------------------------------------

// Holds the characters still owed by the block, oldest first.
class digit_scoreboard;

    typedef struct packed {
        logic [b2d_pkg::CHAR_BITS-1:0] character;
        logic                          last;
    } text_char_t;

    text_char_t pending_chars[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return pending_chars.size();
    endfunction

    task report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Split an accepted number into decimal digits, most significant first.
    function void note_number(input logic [b2d_pkg::VALUE_BITS-1:0] v);
        b2d_pkg::digit_t               rev [b2d_pkg::MAX_DIGITS];
        logic [b2d_pkg::VALUE_BITS-1:0] rest;
        int                            n;
        text_char_t                    c;
        rest = v;
        n    = 0;
        if (rest == '0)
        begin
            rev[0] = '0;
            n      = 1;
        end
        while (rest != '0 && n < b2d_pkg::MAX_DIGITS)
        begin
            rev[n] = b2d_pkg::digit_t'(rest % 10);
            rest   = rest / 10;
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            c.character = b2d_pkg::CHAR_ZERO + b2d_pkg::CHAR_BITS'(rev[k]);
            c.last      = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    task check_char(input logic [b2d_pkg::CHAR_BITS-1:0] character, input logic last);
        text_char_t exp_c;
        if (pending_chars.size() == 0)
        begin
            report_mismatch($sformatf("unexpected character %0d last %0b", character, last));
        end
        else
        begin
            exp_c = pending_chars.pop_front();
            if (character !== exp_c.character)
            begin
                report_mismatch($sformatf("character %0d, expected %0d",
                                          character, exp_c.character));
            end
            if (last !== exp_c.last)
            begin
                report_mismatch($sformatf("last %0b, expected %0b", last, exp_c.last));
            end
        end
    endtask

endclass

module binary_to_decimal_ascii_test;

    logic clk;
    logic rst_n;

    // percentage of cycles in which the sender holds back / the receiver stalls
    int send_idle_pct;
    int ready_stall_pct;

    digit_scoreboard sb;

    b2d_num_if  number_ch ();
    b2d_text_if text_ch ();

    binary_to_decimal_ascii u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .text   (text_ch)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Receiver: ready is redrawn on every falling edge.
    always @(negedge clk)
    begin
        text_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Monitor: a character counts when valid and ready meet at a rising edge.
    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            sb.check_char(text_ch.character, text_ch.last);
        end
    end

    // Offer one number request and hold it until taken. Valid stays high on
    // return; the next call, or the caller, moves it at the next falling edge.
    task automatic send_number(input logic [b2d_pkg::VALUE_BITS-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            number_ch.valid <= 1'b0;
            @(negedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.value <= v;
        do
            @(posedge clk);
        while (!number_ch.ready);
        sb.note_number(v);
    endtask

    // Withdraw the request and let the text channel drain completely.
    task automatic drain_text();
        @(negedge clk);
        number_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mixed digit counts; the full-range draw toggles every value bit.
    function automatic logic [b2d_pkg::VALUE_BITS-1:0] pick_number();
        logic [b2d_pkg::VALUE_BITS-1:0] v;
        case ($urandom_range(3))
            0:       v = b2d_pkg::VALUE_BITS'($urandom);
            1:       v = b2d_pkg::VALUE_BITS'($urandom_range(9));
            2:       v = b2d_pkg::VALUE_BITS'($urandom_range(9999, 10));
            default: v = b2d_pkg::VALUE_BITS'($urandom_range(65535, 10000));
        endcase
        return v;
    endfunction

    // Zero, each digit-count boundary, both ends of the range and
    // alternating bit patterns.
    localparam int N_DIRECTED = 23;
    localparam logic [b2d_pkg::VALUE_BITS-1:0] DIRECTED [N_DIRECTED] = '{
        16'd0,     16'd1,     16'd9,     16'd10,    16'd11,    16'd99,
        16'd100,   16'd909,   16'd999,   16'd1000,  16'd4096,  16'd9999,
        16'd10000, 16'd10001, 16'd12345, 16'd32767, 16'd32768, 16'hAAAA,
        16'h5555,  16'd59999, 16'd60000, 16'd65534, 16'd65535
    };

    initial
    begin
        sb              = new();
        send_idle_pct   = 6;
        ready_stall_pct = 53;
        rst_n           = 1'b0;
        number_ch.valid = 1'b0;
        number_ch.value = '0;
        text_ch.ready   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed requests under the first idling mix
        foreach (DIRECTED[i])
        begin
            send_number(DIRECTED[i]);
        end

        // random phases: slow receiver, then slow sender, then full rate
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct   = 6;
                    ready_stall_pct = 53;
                end
                1:
                begin
                    send_idle_pct   = 53;
                    ready_stall_pct = 6;
                end
                default:
                begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 0;
                end
            endcase
            for (int i = 0; i < 50; i++)
            begin
                // in the first two phases the sender holds off mid-phase until the text channel is empty
                if (i == 25 && phase != 2)
                begin
                    drain_text();
                end
                send_number(pick_number());
            end
        end

        drain_text();
        // pipe is six stages deep; give it a few spare cycles
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("** binary_to_decimal_ascii: PASSED **");
        end
        else
        begin
            $display("** binary_to_decimal_ascii: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #200000;
        $display("** binary_to_decimal_ascii: FAILED **");
        $finish;
    end

endmodule
